@@ design/tsr_pkg.sv @@
package tsr_pkg;

    localparam int X_W      = 18;
    localparam int ROW_W    = 4;
    localparam int LEN_W    = 5;
    localparam int BR_W     = 9;
    localparam int COLOR_W  = 8;
    localparam int CUR_W    = 3;
    localparam int LOC_W    = 5;
    localparam int CONTRIB_W = 16;
    localparam int MASK_W   = 8;

    localparam int DIVIDEND_W = 14;
    localparam int DIVISOR_W  = 9;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 9;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
    } div_rsp_t;

endpackage

@@ design/trail_splat_renderer_unit.sv @@
// Channel  | Handshake                  | Payload
// ---------+----------------------------+---------------------------------------------
// input    | in_valid / in_stall        | star_x, star_row, trail_len, brightness, rgb
// output   | out_valid / out_stall      | pixel_valid, curtain, local_col, out_row,
//          |                            | red_out, green_out, blue_out, last
// config   | cfg_we / cfg_wdata         | invert_mask
//
// One sprite at a time; in_stall is high from acceptance until its last transaction is
// loaded into the output register. Each trail segment uses one pass of the 14-step
// radix-2 divider for the fade, ten passes of the shared 17x9 multiplier and a
// curtain split per pixel by constant compares; output stall can hold each emit.
// Reset clears the sequencer, the output valid and invert_mask; there is no clearing pass.
module trail_splat_renderer_unit
    import tsr_pkg::*;
#(
    parameter int CURTAIN_COLS  = 32,
    parameter int CURTAIN_COUNT = 8,
    parameter int CURTAIN_ROWS  = 16,
    parameter int MAX_TRAIL     = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_we,
    input  logic [MASK_W-1:0]           cfg_wdata,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [X_W-1:0]       star_x,
    input  logic [ROW_W-1:0]            star_row,
    input  logic [LEN_W-1:0]            trail_len,
    input  logic [BR_W-1:0]             brightness,
    input  logic [COLOR_W-1:0]          red,
    input  logic [COLOR_W-1:0]          green,
    input  logic [COLOR_W-1:0]          blue,

    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        pixel_valid,
    output logic [CUR_W-1:0]            curtain,
    output logic [LOC_W-1:0]            local_col,
    output logic [ROW_W-1:0]            out_row,
    output logic [CONTRIB_W-1:0]        red_out,
    output logic [CONTRIB_W-1:0]        green_out,
    output logic [CONTRIB_W-1:0]        blue_out,
    output logic                        last
);

    localparam int LEN_I_W = LEN_W + 1;
    localparam int TX_W    = X_W + 1;
    localparam int COL_W   = TX_W - 8;
    localparam int CURN_W  = 6;
    localparam int BASE_W  = 14;

    localparam logic [LEN_I_W-1:0]    MAX_TRAIL_V = LEN_I_W'(MAX_TRAIL);
    localparam logic [DIVISOR_W-1:0]  ROWS_V      = DIVISOR_W'(CURTAIN_ROWS);
    localparam logic [DIVIDEND_W-1:0] TOTAL_V     =
        DIVIDEND_W'(CURTAIN_COLS * CURTAIN_COUNT);

    typedef enum logic [4:0] {
        S_IDLE,
        S_ZERO,
        S_FADE_GO,
        S_FADE_WAIT,
        S_SB,
        S_SB_CAP,
        S_CS0,
        S_CS1,
        S_CS2,
        S_CS3,
        S_COL,
        S_PX0,
        S_PX1,
        S_PX2,
        S_PX3,
        S_EMIT
    } state_t;

    state_t                  state_reg;
    logic [MASK_W-1:0]       mask_reg;

    logic signed [X_W-1:0]   x_reg;
    logic [ROW_W-1:0]        row_reg;
    logic [LEN_I_W-1:0]      len_reg;
    logic [BR_W-1:0]         br_reg;
    logic [COLOR_W-1:0]      color_reg [3];
    logic [LEN_I_W-1:0]      i_reg;
    logic                    side_reg;

    logic [8:0]              f_reg;
    logic [8:0]              sb_reg;
    logic [MUL_A_W-1:0]      cs_reg [3];
    logic [CONTRIB_W-1:0]    px_reg [3];
    logic [CURN_W-1:0]       cur_reg;
    logic [BASE_W-1:0]       loc_reg;
    logic [PROD_W-1:0]       prod_reg;

    logic                    out_valid_reg;
    logic                    pixel_valid_reg;
    logic [CUR_W-1:0]        curtain_reg;
    logic [LOC_W-1:0]        local_col_reg;
    logic [ROW_W-1:0]        out_row_reg;
    logic [CONTRIB_W-1:0]    red_out_reg;
    logic [CONTRIB_W-1:0]    green_out_reg;
    logic [CONTRIB_W-1:0]    blue_out_reg;
    logic                    last_reg;

    div_req_t                div_req;
    div_rsp_t                div_rsp;

    logic                    in_accept;
    logic                    out_free;
    logic                    out_load;
    logic [LEN_I_W-1:0]      len_sat;
    logic signed [TX_W-1:0]  tx;
    logic signed [COL_W-1:0] col;
    logic [7:0]              frac;
    logic [8:0]              weight;
    logic                    on_screen;
    logic                    mirror;
    logic [ROW_W-1:0]        row_eff;
    logic                    seg_last;
    logic [BASE_W-1:0]       col_idx;
    logic [CURN_W-1:0]       split_cur;
    logic [BASE_W-1:0]       split_base;
    logic [BASE_W-1:0]       split_loc;
    logic [MUL_A_W-1:0]      mul_a;
    logic [MUL_B_W-1:0]      mul_b;
    logic [PROD_W-9:0]       scaled;
    logic [CONTRIB_W-1:0]    sat;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = out_free && ((state_reg == S_ZERO) || (state_reg == S_EMIT));

    assign len_sat = ({1'b0, trail_len} > MAX_TRAIL_V) ? MAX_TRAIL_V : {1'b0, trail_len};

    assign tx     = TX_W'(x_reg) - TX_W'({i_reg, 7'b0});
    assign col    = COL_W'(tx >>> 8) + COL_W'(side_reg);
    assign frac   = tx[7:0];
    assign weight = side_reg ? {1'b0, frac} : 9'd256 - {1'b0, frac};

    assign on_screen = !col[COL_W-1]
                    && (DIVIDEND_W'(col[COL_W-2:0]) < TOTAL_V)
                    && ({5'b0, row_reg} < ROWS_V);
    assign mirror    = (cur_reg < CURN_W'(8)) && mask_reg[cur_reg[2:0]];
    assign row_eff   = mirror ? ROW_W'(ROWS_V - 9'd1 - {5'b0, row_reg}) : row_reg;
    assign seg_last  = side_reg && (i_reg == len_reg - 1'b1);

    // curtain split: parallel compares against constant curtain boundaries
    assign col_idx = BASE_W'(col[COL_W-2:0]);

    always_comb
    begin
        split_cur  = '0;
        split_base = '0;
        for (int k = 1; k < CURTAIN_COUNT; k++)
        begin
            if (col_idx >= BASE_W'(k * CURTAIN_COLS))
            begin
                split_cur  = CURN_W'(k);
                split_base = BASE_W'(k * CURTAIN_COLS);
            end
        end
    end

    assign split_loc = col_idx - split_base;

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            S_FADE_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIVIDEND_W'({len_reg - i_reg, 8'b0});
                div_req.divisor  = DIVISOR_W'(len_reg);
            end
            default:
            begin
            end
        endcase
    end

    tsr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SB:
            begin
                mul_a = MUL_A_W'(f_reg);
                mul_b = br_reg;
            end
            S_CS0:
            begin
                mul_a = MUL_A_W'(color_reg[0]);
                mul_b = sb_reg;
            end
            S_CS1:
            begin
                mul_a = MUL_A_W'(color_reg[1]);
                mul_b = sb_reg;
            end
            S_CS2:
            begin
                mul_a = MUL_A_W'(color_reg[2]);
                mul_b = sb_reg;
            end
            S_PX0:
            begin
                mul_a = cs_reg[0];
                mul_b = weight;
            end
            S_PX1:
            begin
                mul_a = cs_reg[1];
                mul_b = weight;
            end
            S_PX2:
            begin
                mul_a = cs_reg[2];
                mul_b = weight;
            end
            default:
            begin
            end
        endcase
    end

    assign scaled = prod_reg[PROD_W-1:8];
    assign sat    = (|scaled[PROD_W-9:CONTRIB_W]) ? '1 : scaled[CONTRIB_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mask_reg        <= '0;
            out_valid_reg   <= 1'b0;
            i_reg           <= '0;
            side_reg        <= 1'b0;
            len_reg         <= '0;
            pixel_valid_reg <= 1'b0;
            curtain_reg     <= '0;
            local_col_reg   <= '0;
            out_row_reg     <= '0;
            red_out_reg     <= '0;
            green_out_reg   <= '0;
            blue_out_reg    <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mask_reg <= cfg_wdata;
            end
            if (out_valid_reg && !out_stall && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            prod_reg <= {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        x_reg        <= star_x;
                        row_reg      <= star_row;
                        len_reg      <= len_sat;
                        br_reg       <= brightness;
                        color_reg[0] <= red;
                        color_reg[1] <= green;
                        color_reg[2] <= blue;
                        i_reg        <= '0;
                        side_reg     <= 1'b0;
                        state_reg    <= (len_sat == '0) ? S_ZERO : S_FADE_GO;
                    end
                end
                S_ZERO:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        pixel_valid_reg <= 1'b0;
                        curtain_reg     <= '0;
                        local_col_reg   <= '0;
                        out_row_reg     <= '0;
                        red_out_reg     <= '0;
                        green_out_reg   <= '0;
                        blue_out_reg    <= '0;
                        last_reg        <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                end
                S_FADE_GO:
                begin
                    state_reg <= S_FADE_WAIT;
                end
                S_FADE_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        f_reg     <= div_rsp.quotient[8:0];
                        state_reg <= S_SB;
                    end
                end
                S_SB:
                begin
                    state_reg <= S_SB_CAP;
                end
                S_SB_CAP:
                begin
                    sb_reg    <= prod_reg[16:8];
                    state_reg <= S_CS0;
                end
                S_CS0:
                begin
                    state_reg <= S_CS1;
                end
                S_CS1:
                begin
                    cs_reg[0] <= prod_reg[MUL_A_W-1:0];
                    state_reg <= S_CS2;
                end
                S_CS2:
                begin
                    cs_reg[1] <= prod_reg[MUL_A_W-1:0];
                    state_reg <= S_CS3;
                end
                S_CS3:
                begin
                    cs_reg[2] <= prod_reg[MUL_A_W-1:0];
                    state_reg <= S_COL;
                end
                S_COL:
                begin
                    cur_reg   <= split_cur;
                    loc_reg   <= split_loc;
                    state_reg <= S_PX0;
                end
                S_PX0:
                begin
                    state_reg <= S_PX1;
                end
                S_PX1:
                begin
                    px_reg[0] <= sat;
                    state_reg <= S_PX2;
                end
                S_PX2:
                begin
                    px_reg[1] <= sat;
                    state_reg <= S_PX3;
                end
                S_PX3:
                begin
                    px_reg[2] <= sat;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        pixel_valid_reg <= on_screen;
                        curtain_reg     <= on_screen ? cur_reg[CUR_W-1:0] : '0;
                        local_col_reg   <= on_screen ? loc_reg[LOC_W-1:0] : '0;
                        out_row_reg     <= on_screen ? row_eff : '0;
                        red_out_reg     <= on_screen ? px_reg[0] : '0;
                        green_out_reg   <= on_screen ? px_reg[1] : '0;
                        blue_out_reg    <= on_screen ? px_reg[2] : '0;
                        last_reg        <= seg_last;
                        if (!side_reg)
                        begin
                            side_reg  <= 1'b1;
                            state_reg <= S_COL;
                        end
                        else if (seg_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            side_reg  <= 1'b0;
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_FADE_GO;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_valid = pixel_valid_reg;
    assign curtain     = curtain_reg;
    assign local_col   = local_col_reg;
    assign out_row     = out_row_reg;
    assign red_out     = red_out_reg;
    assign green_out   = green_out_reg;
    assign blue_out    = blue_out_reg;
    assign last        = last_reg;

endmodule

@@ design/tsr_div.sv @@
module tsr_div
    import tsr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                  active_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  count_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  den_reg;

    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // restoring step: dividend shifts out of quo_reg, quotient bits shift in
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            count_reg  <= '0;
            rem_reg    <= '0;
            quo_reg    <= '0;
            den_reg    <= '0;
        end
        else
        begin
            if (req.start)
            begin
                active_reg <= 1'b1;
                done_reg   <= 1'b0;
                count_reg  <= '0;
                rem_reg    <= '0;
                quo_reg    <= req.dividend;
                den_reg    <= req.divisor;
            end
            else if (active_reg)
            begin
                rem_reg <= fits ? DIVISOR_W'(trial - {1'b0, den_reg})
                                : trial[DIVISOR_W-1:0];
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
                if (count_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
                else
                begin
                    done_reg  <= 1'b0;
                    count_reg <= count_reg + 1'b1;
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

@@ test/testbench.sv @@
module testbench;
    import tsr_pkg::*;

    localparam int SCREEN_COLS    = 32;
    localparam int CURTAINS       = 8;
    localparam int SCREEN_ROWS    = 16;
    localparam int TRAIL_MAX      = 16;
    localparam int IDLE_PCT       = 17;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;

    class splat_board;
        typedef struct {
            bit                 pv;
            bit [CUR_W-1:0]     cur;
            bit [LOC_W-1:0]     loc;
            bit [ROW_W-1:0]     row;
            bit [CONTRIB_W-1:0] r;
            bit [CONTRIB_W-1:0] g;
            bit [CONTRIB_W-1:0] b;
            bit                 last;
        } pixel_t;

        bit [MASK_W-1:0] mask;
        pixel_t          pending_pixels[$];
        int              errors;
        int              sprites;
        int              pixels;
        int              lit;

        function int pending();
            return pending_pixels.size();
        endfunction

        function bit [CONTRIB_W-1:0] tint(int c, int sb, int w);
            longint v;
            v = (longint'(c) * sb * w) >>> 8;
            return (v > 65535) ? 16'hFFFF : v[CONTRIB_W-1:0];
        endfunction

        function pixel_t splat(int col, int row, int sb, int w, int r, int g, int b);
            pixel_t p;
            int     cur;
            p = '{default: 0};
            if (col < 0 || col >= SCREEN_COLS * CURTAINS || row >= SCREEN_ROWS)
                return p;
            cur   = col / SCREEN_COLS;
            p.pv  = 1'b1;
            p.cur = cur[CUR_W-1:0];
            p.loc = LOC_W'(col % SCREEN_COLS);
            if (cur < 8 && mask[cur])
                p.row = ROW_W'(SCREEN_ROWS - 1 - row);
            else
                p.row = ROW_W'(row);
            p.r = tint(r, sb, w);
            p.g = tint(g, sb, w);
            p.b = tint(b, sb, w);
            return p;
        endfunction

        function void add_sprite(logic signed [X_W-1:0] x, logic [ROW_W-1:0] row,
                                 logic [LEN_W-1:0] tlen, logic [BR_W-1:0] br,
                                 logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                                 logic [COLOR_W-1:0] b);
            pixel_t p;
            int     xi;
            int     len;
            int     tx;
            int     frac;
            int     col;
            int     f;
            int     sb;
            xi = x;
            len = tlen;
            sprites++;
            if (len > TRAIL_MAX)
                len = TRAIL_MAX;
            if (len == 0)
            begin
                p = '{default: 0};
                p.last = 1'b1;
                pending_pixels.push_back(p);
                return;
            end
            for (int i = 0; i < len; i++)
            begin
                tx   = xi - i * 128;
                frac = tx & 255;
                col  = (tx - frac) / 256;
                f    = ((len - i) * 256) / len;
                sb   = (int'(br) * f) >> 8;
                pending_pixels.push_back(splat(col, row, sb, 256 - frac, r, g, b));
                pending_pixels.push_back(splat(col + 1, row, sb, frac, r, g, b));
            end
            pending_pixels[pending_pixels.size() - 1].last = 1'b1;
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void match_pixel(pixel_t got);
            pixel_t want;
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected output transaction");
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            pixels++;
            if (got.pv)
                lit++;
            compare_field("pixel_valid", want.pv, got.pv);
            compare_field("curtain", want.cur, got.cur);
            compare_field("local_col", want.loc, got.loc);
            compare_field("out_row", want.row, got.row);
            compare_field("red_out", want.r, got.r);
            compare_field("green_out", want.g, got.g);
            compare_field("blue_out", want.b, got.b);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [MASK_W-1:0]     cfg_wdata;
    logic                  in_valid;
    logic                  in_stall;
    logic signed [X_W-1:0] star_x;
    logic [ROW_W-1:0]      star_row;
    logic [LEN_W-1:0]      trail_len;
    logic [BR_W-1:0]       brightness;
    logic [COLOR_W-1:0]    red;
    logic [COLOR_W-1:0]    green;
    logic [COLOR_W-1:0]    blue;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  pixel_valid;
    logic [CUR_W-1:0]      curtain;
    logic [LOC_W-1:0]      local_col;
    logic [ROW_W-1:0]      out_row;
    logic [CONTRIB_W-1:0]  red_out;
    logic [CONTRIB_W-1:0]  green_out;
    logic [CONTRIB_W-1:0]  blue_out;
    logic                  last;

    splat_board            board = new;
    splat_board::pixel_t   seen;
    int                    idle_pct = IDLE_PCT;
    int                    quiet_cycles = 0;
    int                    mask_writes = 0;

    trail_splat_renderer_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .star_x      (star_x),
        .star_row    (star_row),
        .trail_len   (trail_len),
        .brightness  (brightness),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_valid (pixel_valid),
        .curtain     (curtain),
        .local_col   (local_col),
        .out_row     (out_row),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen.pv   = pixel_valid;
            seen.cur  = curtain;
            seen.loc  = local_col;
            seen.row  = out_row;
            seen.r    = red_out;
            seen.g    = green_out;
            seen.b    = blue_out;
            seen.last = last;
            board.match_pixel(seen);
        end
        out_stall <= rst_n && (idle_pct > 0) && ($urandom_range(0, 99) < idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_sprite(int x, int row, int len, int br, int r, int g, int b);
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        star_x     <= x[X_W-1:0];
        star_row   <= row[ROW_W-1:0];
        trail_len  <= len[LEN_W-1:0];
        brightness <= br[BR_W-1:0];
        red        <= r[COLOR_W-1:0];
        green      <= g[COLOR_W-1:0];
        blue       <= b[COLOR_W-1:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.add_sprite(star_x, star_row, trail_len, brightness, red, green, blue);
    endtask

    task automatic send_random_sprite();
        int sel;
        int x;
        int len;
        int br;
        sel = $urandom_range(0, 99);
        if (sel < 75)
            x = int'($urandom_range(0, 67584)) - 1024;
        else
            x = $urandom;
        sel = $urandom_range(0, 99);
        if (sel < 5)
            len = 0;
        else if (sel < 65)
            len = $urandom_range(1, 4);
        else if (sel < 88)
            len = $urandom_range(5, 16);
        else
            len = $urandom_range(17, 31);
        sel = $urandom_range(0, 99);
        if (sel < 15)
            br = $urandom_range(0, 511);
        else if (sel < 25)
            br = 256;
        else
            br = $urandom_range(0, 256);
        send_sprite(x, $urandom_range(0, 15), len, br, $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mask(bit [MASK_W-1:0] m);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we     <= 1'b0;
        board.mask = m;
        mask_writes++;
    endtask

    task automatic random_phase(bit [MASK_W-1:0] m, int count, int pct, bit mid_pause);
        drain();
        write_mask(m);
        idle_pct = pct;
        for (int k = 0; k < count; k++)
        begin
            if (mid_pause && k == count / 2)
                drain();
            send_random_sprite();
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= '0;
        in_valid   <= 1'b0;
        star_x     <= '0;
        star_row   <= '0;
        trail_len  <= '0;
        brightness <= '0;
        red        <= '0;
        green      <= '0;
        blue       <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_mask(8'h00);
        send_sprite(0, 0, 0, 256, 255, 255, 255);
        send_sprite(0, 0, 1, 256, 255, 255, 255);
        send_sprite(128, 15, 1, 511, 255, 255, 255);
        send_sprite(-131072, 3, 4, 200, 10, 20, 30);
        send_sprite(131071, 7, 2, 100, 1, 2, 3);
        send_sprite(-1, 5, 3, 256, 255, 0, 128);
        send_sprite(255 * 256 + 128, 9, 2, 256, 77, 88, 99);
        send_sprite(100 * 256 + 255, 2, 16, 256, 255, 255, 255);
        send_sprite(40 * 256 + 77, 4, 31, 180, 9, 99, 199);
        send_sprite(60 * 256, 6, 5, 0, 255, 255, 255);
        send_sprite(31 * 256 + 200, 1, 6, 256, 0, 0, 0);
        send_sprite(7 * 256 + 1, 0, 1, 1, 255, 255, 255);
        send_sprite(90 * 256 + 50, 12, 17, 511, 255, 128, 1);
        drain();

        write_mask(8'hFF);
        send_sprite(33 * 256 + 64, 0, 3, 256, 200, 100, 50);
        send_sprite(250 * 256 + 10, 15, 4, 256, 255, 255, 255);
        send_sprite(-3 * 256, 8, 8, 256, 1, 1, 1);
        send_sprite(0, 15, 0, 511, 255, 255, 255);
        send_sprite(224 * 256 + 128, 10, 2, 300, 255, 255, 255);

        random_phase(8'hFF, 80, IDLE_PCT, 1'b0);
        random_phase(8'($urandom), 80, IDLE_PCT, 1'b1);
        random_phase(8'hA5, 80, 0, 1'b0);
        random_phase(8'h00, 80, IDLE_PCT, 1'b0);
        random_phase(8'h5A, 80, IDLE_PCT, 1'b0);
        drain();

        $display("Run covered %0d sprites, %0d pixel transactions (%0d on screen)",
                 board.sprites, board.pixels, board.lit);
        $display("under %0d invert mask settings, with and without back-pressure",
                 mask_writes);
        if (board.errors == 0 && board.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
